// ===== rtl/ffha_pkg.sv =====
// Shared constants, types and helpers for the first-fit heap allocator.
package ffha_pkg;

   localparam int HEAP_GRANULES   = 1024;
   localparam int GRANULE_BYTES   = 16;
   localparam int HEADER_BYTES    = 8;
   localparam int USABLE_GRANULES = HEAP_GRANULES - 1;

   localparam int IDX_W   = $clog2(HEAP_GRANULES);
   localparam int CNT_W   = IDX_W + 1;
   localparam int HDR_W   = IDX_W + 1;
   localparam int GRAN_SH = $clog2(GRANULE_BYTES);
   localparam int BYTES_W = 14;
   localparam int OFF_W   = 14;
   localparam int SUM_W   = BYTES_W + 1;
   localparam int NEED_W  = SUM_W - GRAN_SH;
   localparam int ROUND_ADD = HEADER_BYTES + GRANULE_BYTES - 1;

   localparam logic OP_ALLOCATE = 1'b0;
   localparam logic OP_RELEASE  = 1'b1;

   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_OOM = 1'b1;

   typedef struct packed {
      logic load;
      logic walk_begin;
      logic merge_step;
      logic fit_step;
      logic take;
      logic extend;
      logic rel_read;
      logic rel_write;
      logic resp_null;
   } ffha_cmd_type;

   typedef struct packed {
      logic heap_nonempty;
      logic walk_done;
      logic fit_hit;
      logic rel_ok;
   } ffha_stat_type;

   function automatic logic [OFF_W-1:0] payload_off(input logic [IDX_W-1:0] g);
      logic [IDX_W:0] n;
      n = {1'b0, g} + CNT_W'(1);
      return OFF_W'({n, GRAN_SH'(0)});
   endfunction

endpackage

// ===== rtl/first_fit_heap_allocator_unit.sv =====
// Top level of the first-fit heap allocator over a region of 16-byte granules.
//
// Requests: a transaction is taken on a rising edge with start high and busy low.
// req_opcode selects allocate or release; req_request_bytes sizes an allocate
// and req_release_offset names the payload to release (zero is null).
// Results: exactly one per request, shown for one cycle with rsp_valid high;
// rsp_payload_offset is the payload byte offset (zero for release or failure)
// and rsp_status flags out of memory. The receiver cannot stall; a result is
// taken at the edge that ends its cycle, and the next request may start then.
// Sequence: a release passes a check state and, for a valid offset, a header
// rewrite state. An allocate on an empty heap goes straight to the extend
// state; otherwise it walks the block headers twice through the single read
// port of the header memory, one header per cycle, a merge pass and then a
// fit pass that ends at the first fit. Busy stays high for the whole walk.
// Reset: the heap is empty after reset; the header memory needs no clearing.
module first_fit_heap_allocator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_opcode,
   input  logic [ffha_pkg::BYTES_W-1:0]        req_request_bytes,
   input  logic [ffha_pkg::OFF_W-1:0]          req_release_offset,
   output logic                               rsp_valid,
   output logic [ffha_pkg::OFF_W-1:0]          rsp_payload_offset,
   output logic                               rsp_status
);

   ffha_pkg::ffha_cmd_type  cmd;
   ffha_pkg::ffha_stat_type stat;

   ffha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_opcode (req_opcode),
      .stat       (stat),
      .busy       (busy),
      .cmd        (cmd)
   );

   ffha_dpath u_dpath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .req_request_bytes  (req_request_bytes),
      .req_release_offset (req_release_offset),
      .stat               (stat),
      .rsp_valid          (rsp_valid),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_status         (rsp_status)
   );

endmodule

// ===== rtl/ffha_ctrl.sv =====
// Sequencing state machine of the first-fit heap allocator.
module ffha_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   req_opcode,
   input  ffha_pkg::ffha_stat_type stat,
   output logic                   busy,
   output ffha_pkg::ffha_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_MERGE  = 4'd1;
   localparam logic [3:0] S_FBEGIN = 4'd2;
   localparam logic [3:0] S_FIT    = 4'd3;
   localparam logic [3:0] S_TAKE   = 4'd4;
   localparam logic [3:0] S_EXT    = 4'd5;
   localparam logic [3:0] S_REL    = 4'd6;
   localparam logic [3:0] S_RELW   = 4'd7;

   logic [3:0] state_ff;
   logic [3:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               if (req_opcode == ffha_pkg::OP_RELEASE) begin
                  state_in = S_REL;
               end else if (stat.heap_nonempty) begin
                  cmd.walk_begin = 1'b1;
                  state_in       = S_MERGE;
               end else begin
                  state_in = S_EXT;
               end
            end
         end
         S_MERGE: begin
            cmd.merge_step = 1'b1;
            if (stat.walk_done) begin
               state_in = S_FBEGIN;
            end
         end
         S_FBEGIN: begin
            cmd.walk_begin = 1'b1;
            state_in       = S_FIT;
         end
         S_FIT: begin
            cmd.fit_step = 1'b1;
            if (stat.fit_hit) begin
               state_in = S_TAKE;
            end else if (stat.walk_done) begin
               state_in = S_EXT;
            end
         end
         S_TAKE: begin
            cmd.take = 1'b1;
            state_in = S_IDLE;
         end
         S_EXT: begin
            cmd.extend = 1'b1;
            state_in   = S_IDLE;
         end
         S_REL: begin
            if (stat.rel_ok) begin
               cmd.rel_read = 1'b1;
               state_in     = S_RELW;
            end else begin
               cmd.resp_null = 1'b1;
               state_in      = S_IDLE;
            end
         end
         S_RELW: begin
            cmd.rel_write = 1'b1;
            cmd.resp_null = 1'b1;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/ffha_dpath.sv =====
// Header memory, heap bookkeeping and walk arithmetic of the heap allocator.
module ffha_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  ffha_pkg::ffha_cmd_type               cmd,
   input  logic [ffha_pkg::BYTES_W-1:0]         req_request_bytes,
   input  logic [ffha_pkg::OFF_W-1:0]           req_release_offset,
   output ffha_pkg::ffha_stat_type              stat,
   output logic                                rsp_valid,
   output logic [ffha_pkg::OFF_W-1:0]           rsp_payload_offset,
   output logic                                rsp_status
);

   localparam int IDX_W  = ffha_pkg::IDX_W;
   localparam int CNT_W  = ffha_pkg::CNT_W;
   localparam int HDR_W  = ffha_pkg::HDR_W;
   localparam int NEED_W = ffha_pkg::NEED_W;
   localparam int OFF_W  = ffha_pkg::OFF_W;
   localparam int SUM_W  = ffha_pkg::SUM_W;
   localparam int GRAN_SH = ffha_pkg::GRAN_SH;

   logic [HDR_W-1:0] hdr_mem_ff [ffha_pkg::HEAP_GRANULES];
   logic [HDR_W-1:0] rdata_ff;
   logic             rd_en;
   logic [IDX_W-1:0] rd_addr;
   logic             wr_en;
   logic [IDX_W-1:0] wr_addr;
   logic [HDR_W-1:0] wr_data;

   logic [IDX_W-1:0]  last_ff, last_in;
   logic [CNT_W-1:0]  brk_ff, brk_in;
   logic              nonempty_ff, nonempty_in;
   logic [NEED_W-1:0] need_ff, need_in;
   logic [OFF_W-1:0]  rel_off_ff, rel_off_in;
   logic [IDX_W-1:0]  cur_ff, cur_in;
   logic [IDX_W-1:0]  cur_sz_ff, cur_sz_in;
   logic              run_ff, run_in;
   logic [IDX_W-1:0]  p_ff, p_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [OFF_W-1:0]  rsp_off_ff, rsp_off_in;
   logic              rsp_status_ff, rsp_status_in;

   logic              h_alloc;
   logic [IDX_W-1:0]  h_raw;
   logic [IDX_W-1:0]  h_size;
   logic              merging;
   logic [IDX_W-1:0]  mrg_sz;
   logic [IDX_W-1:0]  mrg_last;
   logic [CNT_W-1:0]  mrg_nxt;
   logic [CNT_W-1:0]  fit_nxt;
   logic [CNT_W-1:0]  split_at;
   logic              fit_hit;
   logic              ext_ok;
   logic [SUM_W-1:0]  need_sum;
   logic [IDX_W-1:0]  rel_g;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         hdr_mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rdata_ff <= hdr_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff      <= '0;
         brk_ff       <= '0;
         nonempty_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         last_ff      <= last_in;
         brk_ff       <= brk_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      need_ff       <= need_in;
      rel_off_ff    <= rel_off_in;
      cur_ff        <= cur_in;
      cur_sz_ff     <= cur_sz_in;
      run_ff        <= run_in;
      p_ff          <= p_in;
      rsp_off_ff    <= rsp_off_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign h_alloc  = rdata_ff[0];
   assign h_raw    = rdata_ff[HDR_W-1:1];
   assign h_size   = (h_raw == '0) ? IDX_W'(1) : h_raw;
   assign merging  = run_ff && !h_alloc;
   assign mrg_sz   = IDX_W'(cur_sz_ff + h_size);
   assign mrg_last = (last_ff == p_ff) ? cur_ff : last_ff;
   assign mrg_nxt  = merging ? ({1'b0, cur_ff} + {1'b0, mrg_sz})
                             : ({1'b0, p_ff} + {1'b0, h_size});
   assign fit_nxt  = {1'b0, p_ff} + {1'b0, h_size};
   assign fit_hit  = !h_alloc && (NEED_W'(h_size) >= need_ff);
   assign split_at = {1'b0, p_ff} + CNT_W'(need_ff);
   assign ext_ok   = CNT_W'(need_ff) <= (CNT_W'(ffha_pkg::USABLE_GRANULES) - brk_ff);
   assign need_sum = {1'b0, req_request_bytes} + SUM_W'(ffha_pkg::ROUND_ADD);
   assign rel_g    = IDX_W'(rel_off_ff[OFF_W-1:GRAN_SH] - 1'b1);

   always_comb begin
      stat.heap_nonempty = nonempty_ff;
      stat.fit_hit       = fit_hit;
      stat.walk_done     = cmd.merge_step ? (mrg_nxt > {1'b0, (merging ? mrg_last : last_ff)})
                                          : (fit_nxt > {1'b0, last_ff});
      stat.rel_ok        = (rel_off_ff != '0) && (rel_off_ff[GRAN_SH-1:0] == '0)
                           && ({1'b0, rel_g} < brk_ff);
   end

   always_comb begin
      rd_en         = 1'b0;
      rd_addr       = p_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = '0;
      last_in       = last_ff;
      brk_in        = brk_ff;
      nonempty_in   = nonempty_ff;
      need_in       = need_ff;
      rel_off_in    = rel_off_ff;
      cur_in        = cur_ff;
      cur_sz_in     = cur_sz_ff;
      run_in        = run_ff;
      p_in          = p_ff;
      rsp_valid_in  = 1'b0;
      rsp_off_in    = rsp_off_ff;
      rsp_status_in = rsp_status_ff;

      if (cmd.load) begin
         need_in    = need_sum[SUM_W-1:GRAN_SH];
         rel_off_in = req_release_offset;
      end

      if (cmd.walk_begin) begin
         rd_en   = 1'b1;
         rd_addr = '0;
         p_in    = '0;
         run_in  = 1'b0;
      end

      if (cmd.merge_step) begin
         if (merging) begin
            wr_en     = 1'b1;
            wr_addr   = cur_ff;
            wr_data   = {mrg_sz, 1'b0};
            cur_sz_in = mrg_sz;
            last_in   = mrg_last;
         end else begin
            cur_in    = p_ff;
            cur_sz_in = h_size;
            run_in    = !h_alloc;
         end
         if (!stat.walk_done) begin
            rd_en   = 1'b1;
            rd_addr = mrg_nxt[IDX_W-1:0];
            p_in    = mrg_nxt[IDX_W-1:0];
         end
      end

      if (cmd.fit_step) begin
         if (fit_hit) begin
            cur_in = p_ff;
            if (NEED_W'(h_size) > need_ff) begin
               wr_en   = 1'b1;
               wr_addr = split_at[IDX_W-1:0];
               wr_data = {IDX_W'(NEED_W'(h_size) - need_ff), 1'b0};
               if (p_ff == last_ff) begin
                  last_in = split_at[IDX_W-1:0];
               end
            end
         end else if (!stat.walk_done) begin
            rd_en   = 1'b1;
            rd_addr = fit_nxt[IDX_W-1:0];
            p_in    = fit_nxt[IDX_W-1:0];
         end
      end

      if (cmd.take) begin
         wr_en         = 1'b1;
         wr_addr       = cur_ff;
         wr_data       = {IDX_W'(need_ff), 1'b1};
         rsp_valid_in  = 1'b1;
         rsp_off_in    = ffha_pkg::payload_off(cur_ff);
         rsp_status_in = ffha_pkg::STATUS_OK;
      end

      if (cmd.extend) begin
         rsp_valid_in = 1'b1;
         if (ext_ok) begin
            wr_en         = 1'b1;
            wr_addr       = brk_ff[IDX_W-1:0];
            wr_data       = {IDX_W'(need_ff), 1'b1};
            brk_in        = brk_ff + CNT_W'(need_ff);
            nonempty_in   = 1'b1;
            last_in       = brk_ff[IDX_W-1:0];
            rsp_off_in    = ffha_pkg::payload_off(brk_ff[IDX_W-1:0]);
            rsp_status_in = ffha_pkg::STATUS_OK;
         end else begin
            rsp_off_in    = '0;
            rsp_status_in = ffha_pkg::STATUS_OOM;
         end
      end

      if (cmd.rel_read) begin
         rd_en   = 1'b1;
         rd_addr = rel_g;
      end

      if (cmd.rel_write) begin
         wr_en   = 1'b1;
         wr_addr = rel_g;
         wr_data = {rdata_ff[HDR_W-1:1], 1'b0};
      end

      if (cmd.resp_null) begin
         rsp_valid_in  = 1'b1;
         rsp_off_in    = '0;
         rsp_status_in = ffha_pkg::STATUS_OK;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_payload_offset = rsp_off_ff;
   assign rsp_status         = rsp_status_ff;

endmodule

// ===== test/tb_first_fit_heap_allocator_unit.sv =====
// Self-checking testbench for the first-fit heap allocator unit.
module tb_first_fit_heap_allocator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_REQUEST   = 16376;
   localparam int MAX_OFFSET    = 16383;
   localparam int STALL_LIMIT   = 20000;
   localparam int RANDOM_ITEMS  = 267;
   localparam int MAX_LIVE      = 40;
   localparam int FREED_HISTORY = 16;

   typedef struct {
      logic [ffha_pkg::OFF_W-1:0] offset;
      logic                       status;
   } heap_reply_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           start;
   logic                           busy;
   logic                           req_opcode;
   logic [ffha_pkg::BYTES_W-1:0]   req_request_bytes;
   logic [ffha_pkg::OFF_W-1:0]     req_release_offset;
   logic                           rsp_valid;
   logic [ffha_pkg::OFF_W-1:0]     rsp_payload_offset;
   logic                           rsp_status;

   logic [11:0] hdr_mirror [ffha_pkg::HEAP_GRANULES];
   bit          hdr_written [ffha_pkg::HEAP_GRANULES];
   int          mirror_last;
   int          mirror_break;
   bit          mirror_nonempty;

   heap_reply_type pending_results[$];
   int             live_offsets[$];
   int             freed_offsets[$];
   bit             sender_idling = 1'b1;
   int             error_count = 0;
   int             stall_cycles = 0;

   first_fit_heap_allocator_unit dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_opcode         (req_opcode),
      .req_request_bytes  (req_request_bytes),
      .req_release_offset (req_release_offset),
      .rsp_valid          (rsp_valid),
      .rsp_payload_offset (rsp_payload_offset),
      .rsp_status         (rsp_status)
   );

   always #5ns clock = ~clock;

   function automatic int block_granules(input int g);
      int s;
      s = int'(hdr_mirror[g][11:1]);
      return (s == 0) ? 1 : s;
   endfunction

   function automatic bit block_in_use(input int g);
      return hdr_mirror[g][0];
   endfunction

   function automatic void write_header(input int g, input int size, input bit taken);
      hdr_mirror[g]  = {11'(size), taken};
      hdr_written[g] = 1'b1;
   endfunction

   function automatic void coalesce_free_runs();
      int cur;
      int nxt;
      if (!mirror_nonempty) return;
      cur = 0;
      while (cur <= mirror_last) begin
         nxt = cur + block_granules(cur);
         if (!block_in_use(cur) && nxt <= mirror_last && !block_in_use(nxt)) begin
            while (nxt <= mirror_last && !block_in_use(nxt)) begin
               write_header(cur, block_granules(cur) + block_granules(nxt), 1'b0);
               if (mirror_last == nxt) mirror_last = cur;
               nxt = cur + block_granules(cur);
            end
         end
         cur += block_granules(cur);
      end
   endfunction

   function automatic heap_reply_type allocate_granules(input int bytes);
      heap_reply_type reply;
      int need;
      int g;
      int sz;
      need = (bytes + ffha_pkg::HEADER_BYTES + ffha_pkg::GRANULE_BYTES - 1)
             / ffha_pkg::GRANULE_BYTES;
      reply.offset = '0;
      reply.status = ffha_pkg::STATUS_OK;
      coalesce_free_runs();
      if (mirror_nonempty) begin
         g = 0;
         while (g <= mirror_last) begin
            sz = block_granules(g);
            if (!block_in_use(g) && sz >= need) begin
               if (sz > need) begin
                  write_header(g + need, sz - need, 1'b0);
                  if (g == mirror_last) mirror_last = g + need;
               end
               write_header(g, need, 1'b1);
               reply.offset = ffha_pkg::OFF_W'((g + 1) * ffha_pkg::GRANULE_BYTES);
               return reply;
            end
            g += sz;
         end
      end
      if (need > ffha_pkg::USABLE_GRANULES - mirror_break) begin
         reply.status = ffha_pkg::STATUS_OOM;
      end else begin
         g = mirror_break;
         mirror_break += need;
         mirror_nonempty = 1'b1;
         mirror_last = g;
         write_header(g, need, 1'b1);
         reply.offset = ffha_pkg::OFF_W'((g + 1) * ffha_pkg::GRANULE_BYTES);
      end
      return reply;
   endfunction

   function automatic heap_reply_type predict_heap_reply(input logic op, input int bytes,
                                                         input int off);
      heap_reply_type reply;
      int g;
      reply.offset = '0;
      reply.status = ffha_pkg::STATUS_OK;
      if (op == ffha_pkg::OP_ALLOCATE) return allocate_granules(bytes);
      if (off != 0 && off % ffha_pkg::GRANULE_BYTES == 0) begin
         g = off / ffha_pkg::GRANULE_BYTES - 1;
         if (g < mirror_break) hdr_mirror[g][0] = 1'b0;
      end
      return reply;
   endfunction

   // A release may only touch a header entry that has been written at some point.
   function automatic bit release_is_safe(input int off);
      int g;
      if (off == 0 || off % ffha_pkg::GRANULE_BYTES != 0) return 1'b1;
      g = off / ffha_pkg::GRANULE_BYTES - 1;
      if (g >= mirror_break) return 1'b1;
      return hdr_written[g];
   endfunction

   task automatic send_item(input logic op, input int bytes, input int off);
      heap_reply_type predicted;
      int gap;
      int k;
      if (sender_idling && $urandom_range(99) < 8) begin
         start <= 1'b0;
         gap = $urandom_range(1, 6);
         repeat (gap) @(negedge clock);
      end
      start              <= 1'b1;
      req_opcode         <= op;
      req_request_bytes  <= ffha_pkg::BYTES_W'(bytes);
      req_release_offset <= ffha_pkg::OFF_W'(off);
      do @(posedge clock); while (busy);
      predicted = predict_heap_reply(op, bytes, off);
      pending_results.push_back(predicted);
      if (op == ffha_pkg::OP_ALLOCATE && predicted.offset != 0) begin
         live_offsets.push_back(int'(predicted.offset));
      end else if (op == ffha_pkg::OP_RELEASE) begin
         for (k = 0; k < live_offsets.size(); k++) begin
            if (live_offsets[k] == off) begin
               live_offsets.delete(k);
               freed_offsets.push_back(off);
               if (freed_offsets.size() > FREED_HISTORY) void'(freed_offsets.pop_front());
               break;
            end
         end
      end
      @(negedge clock);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic test_empty_heap_releases();
      send_item(ffha_pkg::OP_RELEASE, $urandom_range(0, MAX_REQUEST), 0);
      send_item(ffha_pkg::OP_RELEASE, $urandom_range(0, MAX_REQUEST), MAX_OFFSET - 15);
      send_item(ffha_pkg::OP_RELEASE, $urandom_range(0, MAX_REQUEST), MAX_OFFSET);
   endtask

   task automatic test_first_allocations();
      send_item(ffha_pkg::OP_ALLOCATE, 0, $urandom_range(0, MAX_OFFSET));
      send_item(ffha_pkg::OP_ALLOCATE, 8, $urandom_range(0, MAX_OFFSET));
      send_item(ffha_pkg::OP_ALLOCATE, 9, $urandom_range(0, MAX_OFFSET));
      send_item(ffha_pkg::OP_RELEASE, $urandom_range(0, MAX_REQUEST), 17);
      send_item(ffha_pkg::OP_RELEASE, $urandom_range(0, MAX_REQUEST), 32);
      send_item(ffha_pkg::OP_RELEASE, $urandom_range(0, MAX_REQUEST), 32);
      send_item(ffha_pkg::OP_RELEASE, $urandom_range(0, MAX_REQUEST), 16);
      send_item(ffha_pkg::OP_ALLOCATE, 20, $urandom_range(0, MAX_OFFSET));
      // Granule 1 is now inside the merged block at granule 0.
      send_item(ffha_pkg::OP_RELEASE, $urandom_range(0, MAX_REQUEST), 32);
   endtask

   task automatic test_heap_exhaustion();
      int fill_bytes;
      fill_bytes = (ffha_pkg::USABLE_GRANULES - mirror_break) * ffha_pkg::GRANULE_BYTES
                   - ffha_pkg::HEADER_BYTES;
      send_item(ffha_pkg::OP_ALLOCATE, MAX_REQUEST, $urandom_range(0, MAX_OFFSET));
      send_item(ffha_pkg::OP_ALLOCATE, fill_bytes + ffha_pkg::GRANULE_BYTES,
                $urandom_range(0, MAX_OFFSET));
      send_item(ffha_pkg::OP_ALLOCATE, fill_bytes, $urandom_range(0, MAX_OFFSET));
      send_item(ffha_pkg::OP_ALLOCATE, 0, $urandom_range(0, MAX_OFFSET));
   endtask

   task automatic test_merge_and_split();
      send_item(ffha_pkg::OP_RELEASE, $urandom_range(0, MAX_REQUEST), live_offsets[$]);
      send_item(ffha_pkg::OP_ALLOCATE, 100, $urandom_range(0, MAX_OFFSET));
      while (live_offsets.size() != 0) begin
         send_item(ffha_pkg::OP_RELEASE, $urandom_range(0, MAX_REQUEST), live_offsets[0]);
      end
      send_item(ffha_pkg::OP_ALLOCATE, 0, $urandom_range(0, MAX_OFFSET));
   endtask

   task automatic test_random_traffic();
      int i;
      int pick;
      int bytes;
      int off;
      int alloc_share;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
         sender_idling = !(i >= 60 && i < 130);
         if (i == 180) wait_drained();
         alloc_share = (live_offsets.size() > MAX_LIVE) ? 35 : 55;
         bytes = $urandom_range(0, MAX_REQUEST);
         off = $urandom_range(0, MAX_OFFSET);
         if (live_offsets.size() == 0 || $urandom_range(99) < alloc_share) begin
            pick = $urandom_range(99);
            if (pick < 70) bytes = $urandom_range(0, 255);
            else if (pick < 92) bytes = $urandom_range(256, 2047);
            send_item(ffha_pkg::OP_ALLOCATE, bytes, off);
         end else begin
            pick = $urandom_range(99);
            if (pick < 75) begin
               off = live_offsets[$urandom_range(live_offsets.size() - 1)];
            end else if (pick < 85 && freed_offsets.size() != 0) begin
               off = freed_offsets[$urandom_range(freed_offsets.size() - 1)];
            end else if (!release_is_safe(off)) begin
               off = off | 1;
            end
            send_item(ffha_pkg::OP_RELEASE, bytes, off);
         end
      end
   endtask

   always @(posedge clock) begin
      heap_reply_type want;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: payload_offset %0d, status %0d",
                   rsp_payload_offset, rsp_status);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload_offset !== want.offset) begin
               $error("payload_offset: expected %0d, actual %0d",
                      want.offset, rsp_payload_offset);
               error_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_status);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end
      end
   end

   initial begin
      foreach (hdr_mirror[g]) begin
         hdr_mirror[g]  = '0;
         hdr_written[g] = 1'b0;
      end
      mirror_last        = 0;
      mirror_break       = 0;
      mirror_nonempty    = 1'b0;
      reset              = 1'b1;
      start              = 1'b0;
      req_opcode         = ffha_pkg::OP_ALLOCATE;
      req_request_bytes  = '0;
      req_release_offset = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_heap_releases();
      test_first_allocations();
      test_heap_exhaustion();
      test_merge_and_split();
      test_random_traffic();
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/ffha_pkg.sv
rtl/ffha_ctrl.sv
rtl/ffha_dpath.sv
rtl/first_fit_heap_allocator_unit.sv
test/tb_first_fit_heap_allocator_unit.sv
